>>> rtl/csa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csa_pkg
// Widths, register indexes, reset values and constants of the current sense
// averager.
// ----------------------------------------------------------------------------
package csa_pkg;

   // field widths
   localparam int SAMPLE_W   = 16;
   localparam int MA_W       = 24;
   localparam int AVG_W      = 16;
   localparam int UV_W       = 24;
   localparam int RSP_DATA_W = 72;

   // configuration port
   localparam int CFG_W     = 24;
   localparam int CFG_IDX_W = 3;

   localparam logic [CFG_IDX_W-1:0] REG_ZERO_DEFAULT = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_SENS         = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_REF          = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_FULL         = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT  = 3'd6;

   localparam int ZERO_W  = 24;
   localparam int SENS_W  = 20;
   localparam int SCALE_W = 16;
   localparam int REF_W   = 13;
   localparam int FULL_W  = 16;
   localparam int AVGC_W  = 8;
   localparam int CALC_W  = 16;

   localparam logic [ZERO_W-1:0]  ZERO_RST  = 24'd2500000;
   localparam logic [SENS_W-1:0]  SENS_RST  = 20'd185000;
   localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
   localparam logic [REF_W-1:0]   REF_RST   = 13'd3300;
   localparam logic [FULL_W-1:0]  FULL_RST  = 16'd4095;
   localparam logic [AVGC_W-1:0]  AVGC_RST  = 8'd20;
   localparam logic [CALC_W-1:0]  CALC_RST  = 16'd50;

   // substitutes for zero settings
   localparam logic [FULL_W-1:0]  FULL_ZERO_SUB  = 16'd4095;
   localparam logic [SCALE_W-1:0] SCALE_ZERO_SUB = 16'd256;
   localparam logic [SENS_W-1:0]  SENS_ZERO_SUB  = 20'd1;
   localparam logic [CALC_W-1:0]  CALC_ZERO_SUB  = 16'd200;

   // run control
   localparam int                  TALLY_W     = 8;
   localparam logic [TALLY_W-1:0]  CALIB_LIMIT = 8'd50;
   localparam logic [TALLY_W-1:0]  MEAS_MIN    = 8'd1;

   // shared shift-add / shift-subtract unit
   localparam int SH_W      = 48;
   localparam int QUO_W     = 47;
   localparam int DEN_W     = 32;
   localparam int MPL_W     = 18;
   localparam int CNT_W     = 6;
   localparam int UV_PROD_W = 47;
   localparam int MA_PROD_W = 34;
   localparam int MAG_W     = 25;

   localparam logic [MPL_W-1:0] UV_FACTOR = 18'd256000;
   localparam logic [MPL_W-1:0] MA_FACTOR = 18'd1000;

   localparam logic [MA_W-1:0] MA_POS_MAX = 24'h7FFFFF;
   localparam logic [MA_W-1:0] MA_NEG_MIN = 24'h800000;
   localparam logic [UV_W-1:0] UV_MAX     = 24'hFFFFFF;

   localparam logic [0:0] OP_MEASURE = 1'b0;
   localparam logic [0:0] OP_CALIB   = 1'b1;

endpackage

>>> rtl/current_sense_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_sense_averager
// Averages ADC beats over a run and turns the average into a sensor voltage
// and a current, or into a new zero-current voltage after a calibration run.
//
// req: one ADC sample a beat, tuser = 1 for a calibration sample. A change of
// kind drops the partial run. Samples are taken one a cycle while no run is
// being finished; the beat that completes a run starts the arithmetic and
// req_tready stays low until its result sits in the output register.
// rsp: one beat per completed run, tuser = 1 when it ended a calibration run.
// Finishing a run is done on one bit-serial shift-add / shift-subtract unit:
// average divide (SAMPLE_BITS + 8 steps), full*scale (16), avg*ref (13),
// *256000 (18), voltage divide (47), and for measurements *1000 (10) and the
// current divide (34), plus a set-up step per phase.
// csr: write strobe, index and data; registers are to be written by the user
// only while the block is idle; the block itself does not enforce this.
// Reset clears the run, loads the register defaults and forgets calibration.
// A stalled rsp beat is held; the block keeps taking samples and only waits
// when a further result is ready before the held one has gone.
// ----------------------------------------------------------------------------
module current_sense_averager #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [csa_pkg::SAMPLE_W-1:0]            req_tdata,   // sample
   input  logic                                    req_tuser,   // operation
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // current_ma[23:0], average_code[39:24], sensor_uv[63:40], adc_ok[64], zeros
   output logic [csa_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                    rsp_tuser,   // was_calibration
   input  logic                                    csr_wr_en,
   input  logic [csa_pkg::CFG_IDX_W-1:0]           csr_index,
   input  logic [csa_pkg::CFG_W-1:0]               csr_wdata
);

   localparam int SUM_W = SAMPLE_BITS + csa_pkg::TALLY_W;
   localparam int CMP_W = SUM_W + 1;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DIV_AVG = 4'd1;
   localparam logic [3:0] S_MUL_DEN = 4'd2;
   localparam logic [3:0] S_MUL_REF = 4'd3;
   localparam logic [3:0] S_MUL_K   = 4'd4;
   localparam logic [3:0] S_DIV_UV  = 4'd5;
   localparam logic [3:0] S_MUL_MA  = 4'd6;
   localparam logic [3:0] S_DIV_MA  = 4'd7;
   localparam logic [3:0] S_DONE    = 4'd8;

   // configuration registers
   logic [csa_pkg::ZERO_W-1:0]  zero_default_ff;
   logic [csa_pkg::SENS_W-1:0]  sens_ff;
   logic [csa_pkg::SCALE_W-1:0] scale_ff;
   logic [csa_pkg::REF_W-1:0]   ref_ff;
   logic [csa_pkg::FULL_W-1:0]  full_ff;
   logic [csa_pkg::AVGC_W-1:0]  avg_count_ff;
   logic [csa_pkg::CALC_W-1:0]  calib_count_ff;

   logic [3:0]                    state_ff, state_in;
   logic [csa_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [csa_pkg::SH_W-1:0]      sh_ff, sh_in;
   logic [csa_pkg::SH_W-1:0]      acc_ff, acc_in;
   logic [csa_pkg::QUO_W-1:0]     q_ff, q_in;
   logic [csa_pkg::DEN_W-1:0]     rem_ff, rem_in;
   logic [csa_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [csa_pkg::MPL_W-1:0]     mplier_ff, mplier_in;
   logic [SUM_W-1:0]              avg_ff, avg_in;
   logic [csa_pkg::UV_W-1:0]      uv_ff, uv_in;
   logic                          neg_ff, neg_in;
   logic [csa_pkg::MA_W-1:0]      ma_ff, ma_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [csa_pkg::TALLY_W-1:0]   tally_ff, tally_in;
   logic                          run_op_ff, run_op_in;
   logic [csa_pkg::ZERO_W-1:0]    zero_ff, zero_in;
   logic                          zero_loaded_ff, zero_loaded_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [csa_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   // effective settings
   logic [csa_pkg::FULL_W-1:0]  full_eff;
   logic [csa_pkg::SCALE_W-1:0] scale_eff;
   logic [csa_pkg::SENS_W-1:0]  sens_eff;
   logic [csa_pkg::CALC_W-1:0]  calib_req;
   logic [csa_pkg::TALLY_W-1:0] target;

   // sample step
   logic                        req_acc;
   logic                        restart;
   logic [SUM_W-1:0]            sum_new;
   logic [csa_pkg::TALLY_W-1:0] tally_new;

   // serial unit step
   logic [csa_pkg::DEN_W:0]     rem_shift;
   logic [csa_pkg::DEN_W+1:0]   rem_diff;
   logic                        q_bit;
   logic [csa_pkg::DEN_W-1:0]   rem_step;
   logic [csa_pkg::QUO_W-1:0]   q_step;
   logic [csa_pkg::SH_W-1:0]    sh_shift;
   logic [csa_pkg::SH_W-1:0]    acc_step;
   logic                        cnt_zero;

   // result shaping
   logic [csa_pkg::FULL_W-1:0]  clamped;
   logic [csa_pkg::UV_W-1:0]    uv_sat;
   logic [csa_pkg::ZERO_W-1:0]  zero_sel;
   logic [csa_pkg::MAG_W-1:0]   diff;
   logic [csa_pkg::MAG_W-1:0]   mag;
   logic [csa_pkg::MA_PROD_W-1:0] ma_mag;
   logic [csa_pkg::MA_W-1:0]    ma_sat;
   logic [CMP_W-1:0]            avg_cmp;
   logic                        adc_ok;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign full_eff  = (full_ff == '0) ? csa_pkg::FULL_ZERO_SUB : full_ff;
   assign scale_eff = (scale_ff == '0) ? csa_pkg::SCALE_ZERO_SUB : scale_ff;
   assign sens_eff  = (sens_ff == '0) ? csa_pkg::SENS_ZERO_SUB : sens_ff;
   assign calib_req = (calib_count_ff == '0) ? csa_pkg::CALC_ZERO_SUB : calib_count_ff;

   always_comb begin
      if (req_tuser == csa_pkg::OP_CALIB) begin
         if (calib_req > csa_pkg::CALC_W'(csa_pkg::CALIB_LIMIT)) begin
            target = csa_pkg::CALIB_LIMIT;
         end else begin
            target = calib_req[csa_pkg::TALLY_W-1:0];
         end
      end else begin
         target = (avg_count_ff == '0) ? csa_pkg::MEAS_MIN : avg_count_ff;
      end
   end

   assign restart   = (req_tuser != run_op_ff);
   assign sum_new   = (restart ? '0 : sum_ff) + SUM_W'(req_tdata[SAMPLE_BITS-1:0]);
   assign tally_new = (restart ? '0 : tally_ff) + csa_pkg::TALLY_W'(1);

   // one restoring divide step and one shift-add multiply step
   assign rem_shift = {rem_ff, sh_ff[csa_pkg::SH_W-1]};
   assign rem_diff  = {1'b0, rem_shift} - {2'b00, den_ff};
   assign q_bit     = ~rem_diff[csa_pkg::DEN_W+1];
   assign rem_step  = q_bit ? rem_diff[csa_pkg::DEN_W-1:0]
                            : rem_shift[csa_pkg::DEN_W-1:0];
   assign q_step    = {q_ff[csa_pkg::QUO_W-2:0], q_bit};
   assign sh_shift  = {sh_ff[csa_pkg::SH_W-2:0], 1'b0};
   assign acc_step  = acc_ff + (mplier_ff[0] ? sh_ff : '0);
   assign cnt_zero  = (cnt_ff == '0);

   assign clamped = (avg_ff > SUM_W'(full_eff)) ? full_eff : avg_ff[csa_pkg::FULL_W-1:0];
   assign uv_sat  = (q_ff[csa_pkg::QUO_W-1:csa_pkg::UV_W] != '0) ? csa_pkg::UV_MAX
                                                               : q_ff[csa_pkg::UV_W-1:0];
   assign zero_sel = zero_loaded_ff ? zero_ff : zero_default_ff;
   assign diff     = {1'b0, uv_sat} - {1'b0, zero_sel};
   assign mag      = diff[csa_pkg::MAG_W-1] ? (~diff + csa_pkg::MAG_W'(1)) : diff;

   assign ma_mag = q_ff[csa_pkg::MA_PROD_W-1:0];
   always_comb begin
      if (neg_ff) begin
         if (ma_mag > csa_pkg::MA_PROD_W'(csa_pkg::MA_NEG_MIN)) begin
            ma_sat = csa_pkg::MA_NEG_MIN;
         end else begin
            ma_sat = ~ma_mag[csa_pkg::MA_W-1:0] + csa_pkg::MA_W'(1);
         end
      end else begin
         if (ma_mag > csa_pkg::MA_PROD_W'(csa_pkg::MA_POS_MAX)) begin
            ma_sat = csa_pkg::MA_POS_MAX;
         end else begin
            ma_sat = ma_mag[csa_pkg::MA_W-1:0];
         end
      end
   end

   assign avg_cmp = CMP_W'(avg_ff);
   assign adc_ok  = !((avg_cmp <= CMP_W'(2)) ||
                      (avg_cmp + CMP_W'(2) >= CMP_W'(full_eff)));

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      sh_in          = sh_ff;
      acc_in         = acc_ff;
      q_in           = q_ff;
      rem_in         = rem_ff;
      den_in         = den_ff;
      mplier_in      = mplier_ff;
      avg_in         = avg_ff;
      uv_in          = uv_ff;
      neg_in         = neg_ff;
      ma_in          = ma_ff;
      sum_in         = sum_ff;
      tally_in       = tally_ff;
      run_op_in      = run_op_ff;
      zero_in        = zero_ff;
      zero_loaded_in = zero_loaded_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               run_op_in = req_tuser;
               if (tally_new >= target) begin
                  sum_in   = '0;
                  tally_in = '0;
                  sh_in    = {sum_new, {(csa_pkg::SH_W-SUM_W){1'b0}}};
                  den_in   = csa_pkg::DEN_W'(target);
                  rem_in   = '0;
                  q_in     = '0;
                  cnt_in   = csa_pkg::CNT_W'(SUM_W);
                  state_in = S_DIV_AVG;
               end else begin
                  sum_in   = sum_new;
                  tally_in = tally_new;
               end
            end
         end
         S_DIV_AVG: begin
            if (cnt_zero) begin
               avg_in    = q_ff[SUM_W-1:0];
               sh_in     = csa_pkg::SH_W'(full_eff);
               mplier_in = csa_pkg::MPL_W'(scale_eff);
               acc_in    = '0;
               cnt_in    = csa_pkg::CNT_W'(csa_pkg::SCALE_W);
               state_in  = S_MUL_DEN;
            end else begin
               sh_in  = sh_shift;
               rem_in = rem_step;
               q_in   = q_step;
               cnt_in = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_MUL_DEN: begin
            if (cnt_zero) begin
               den_in    = acc_ff[csa_pkg::DEN_W-1:0];
               sh_in     = csa_pkg::SH_W'(clamped);
               mplier_in = csa_pkg::MPL_W'(ref_ff);
               acc_in    = '0;
               cnt_in    = csa_pkg::CNT_W'(csa_pkg::REF_W);
               state_in  = S_MUL_REF;
            end else begin
               acc_in    = acc_step;
               sh_in     = sh_shift;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_MUL_REF: begin
            if (cnt_zero) begin
               sh_in     = acc_ff;
               mplier_in = csa_pkg::UV_FACTOR;
               acc_in    = '0;
               cnt_in    = csa_pkg::CNT_W'(csa_pkg::MPL_W);
               state_in  = S_MUL_K;
            end else begin
               acc_in    = acc_step;
               sh_in     = sh_shift;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_MUL_K: begin
            if (cnt_zero) begin
               sh_in    = {acc_ff[csa_pkg::UV_PROD_W-1:0],
                           {(csa_pkg::SH_W-csa_pkg::UV_PROD_W){1'b0}}};
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = csa_pkg::CNT_W'(csa_pkg::UV_PROD_W);
               state_in = S_DIV_UV;
            end else begin
               acc_in    = acc_step;
               sh_in     = sh_shift;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_DIV_UV: begin
            if (cnt_zero) begin
               uv_in = uv_sat;
               if (run_op_ff == csa_pkg::OP_CALIB) begin
                  zero_in        = uv_sat;
                  zero_loaded_in = 1'b1;
                  ma_in          = '0;
                  state_in       = S_DONE;
               end else begin
                  neg_in    = diff[csa_pkg::MAG_W-1];
                  sh_in     = csa_pkg::SH_W'(mag);
                  mplier_in = csa_pkg::MA_FACTOR;
                  acc_in    = '0;
                  cnt_in    = csa_pkg::CNT_W'(10);
                  state_in  = S_MUL_MA;
               end
            end else begin
               sh_in  = sh_shift;
               rem_in = rem_step;
               q_in   = q_step;
               cnt_in = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_MUL_MA: begin
            if (cnt_zero) begin
               sh_in    = {acc_ff[csa_pkg::MA_PROD_W-1:0],
                           {(csa_pkg::SH_W-csa_pkg::MA_PROD_W){1'b0}}};
               den_in   = csa_pkg::DEN_W'(sens_eff);
               rem_in   = '0;
               q_in     = '0;
               cnt_in   = csa_pkg::CNT_W'(csa_pkg::MA_PROD_W);
               state_in = S_DIV_MA;
            end else begin
               acc_in    = acc_step;
               sh_in     = sh_shift;
               mplier_in = mplier_ff >> 1;
               cnt_in    = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_DIV_MA: begin
            if (cnt_zero) begin
               ma_in    = ma_sat;
               state_in = S_DONE;
            end else begin
               sh_in  = sh_shift;
               rem_in = rem_step;
               q_in   = q_step;
               cnt_in = cnt_ff - csa_pkg::CNT_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(csa_pkg::RSP_DATA_W-65){1'b0}}, adc_ok, uv_ff,
                               avg_ff[csa_pkg::AVG_W-1:0], ma_ff};
               rsp_user_in  = run_op_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         sum_ff         <= '0;
         tally_ff       <= '0;
         run_op_ff      <= csa_pkg::OP_MEASURE;
         zero_ff        <= csa_pkg::ZERO_RST;
         zero_loaded_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         sum_ff         <= sum_in;
         tally_ff       <= tally_in;
         run_op_ff      <= run_op_in;
         zero_ff        <= zero_in;
         zero_loaded_ff <= zero_loaded_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff       <= sh_in;
      acc_ff      <= acc_in;
      q_ff        <= q_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      mplier_ff   <= mplier_in;
      avg_ff      <= avg_in;
      uv_ff       <= uv_in;
      neg_ff      <= neg_in;
      ma_ff       <= ma_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_default_ff <= csa_pkg::ZERO_RST;
         sens_ff         <= csa_pkg::SENS_RST;
         scale_ff        <= csa_pkg::SCALE_RST;
         ref_ff          <= csa_pkg::REF_RST;
         full_ff         <= csa_pkg::FULL_RST;
         avg_count_ff    <= csa_pkg::AVGC_RST;
         calib_count_ff  <= csa_pkg::CALC_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            csa_pkg::REG_ZERO_DEFAULT: zero_default_ff <= csr_wdata[csa_pkg::ZERO_W-1:0];
            csa_pkg::REG_SENS:         sens_ff         <= csr_wdata[csa_pkg::SENS_W-1:0];
            csa_pkg::REG_SCALE:        scale_ff        <= csr_wdata[csa_pkg::SCALE_W-1:0];
            csa_pkg::REG_REF:          ref_ff          <= csr_wdata[csa_pkg::REF_W-1:0];
            csa_pkg::REG_FULL:         full_ff         <= csr_wdata[csa_pkg::FULL_W-1:0];
            csa_pkg::REG_AVG_COUNT:    avg_count_ff    <= csr_wdata[csa_pkg::AVGC_W-1:0];
            csa_pkg::REG_CALIB_COUNT:  calib_count_ff  <= csr_wdata[csa_pkg::CALC_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

>>> sim/current_sense_averager_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_sense_averager_checker
// Watches the csr, req and rsp channels of the current sense averager. Keeps
// its own copy of the registers and of the run state, works out the reading
// that each completing sample beat must give, and compares every rsp beat
// field by field with the oldest reading still owed. Counts mismatches,
// unexpected readings, and reports how many readings are still owed.
// ----------------------------------------------------------------------------
module current_sense_averager_checker
   import csa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [CFG_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int unsigned           mismatch_count,
   output int unsigned           readings_pending
);

   localparam int     RAIL_MARGIN = 2;
   localparam longint MA_HI       = 64'sd8388607;
   localparam longint MA_LO       = -64'sd8388608;
   localparam int     REPORT_MAX  = 10;

   typedef struct packed {
      logic [MA_W-1:0]  current_ma;
      logic [AVG_W-1:0] average_code;
      logic [UV_W-1:0]  sensor_uv;
      logic             adc_ok;
      logic             was_calibration;
   } reading_t;

   logic [ZERO_W-1:0]  cfg_zero_default;
   logic [SENS_W-1:0]  cfg_sens;
   logic [SCALE_W-1:0] cfg_scale;
   logic [REF_W-1:0]   cfg_ref;
   logic [FULL_W-1:0]  cfg_full;
   logic [AVGC_W-1:0]  cfg_avg_count;
   logic [CALC_W-1:0]  cfg_calib_count;

   logic [31:0]        run_sum;
   logic [TALLY_W-1:0] run_tally;
   logic               run_op;
   logic [UV_W-1:0]    zero_offset_uv;
   logic               zero_loaded;

   reading_t expected_readings [$];

   initial begin
      mismatch_count   = 0;
      readings_pending = 0;
   end

   // adds one sample to the run, returns 1 with the reading when the run ends
   function automatic bit accumulate_sample(input logic op, input logic [SAMPLE_W-1:0] smp,
                                            output reading_t rd);
      logic [31:0] target, avg, clamped, full, scale, sens, zero;
      logic [63:0] uv_wide;
      longint      ma;
      rd = '0;
      if (op != run_op) begin
         run_sum   = '0;
         run_tally = '0;
         run_op    = op;
      end
      run_sum   = run_sum + smp;
      run_tally = run_tally + 1'b1;
      if (op == OP_MEASURE) begin
         target = (cfg_avg_count == 0) ? 32'(MEAS_MIN) : 32'(cfg_avg_count);
      end else begin
         target = (cfg_calib_count == 0) ? 32'(CALC_ZERO_SUB) : 32'(cfg_calib_count);
         if (target > 32'(CALIB_LIMIT)) target = 32'(CALIB_LIMIT);
      end
      if (32'(run_tally) < target) return 1'b0;

      avg       = run_sum / target;
      run_sum   = '0;
      run_tally = '0;

      full  = (cfg_full == 0) ? 32'(FULL_ZERO_SUB) : 32'(cfg_full);
      scale = (cfg_scale == 0) ? 32'(SCALE_ZERO_SUB) : 32'(cfg_scale);
      sens  = (cfg_sens == 0) ? 32'(SENS_ZERO_SUB) : 32'(cfg_sens);

      clamped = (avg > full) ? full : avg;
      uv_wide = (64'(clamped) * 64'(cfg_ref) * 64'(UV_FACTOR)) / (64'(full) * 64'(scale));
      if (uv_wide > 64'(UV_MAX)) uv_wide = 64'(UV_MAX);

      rd.adc_ok = (int'(avg) <= RAIL_MARGIN || int'(avg) >= int'(full) - RAIL_MARGIN)
                  ? 1'b0 : 1'b1;

      if (op == OP_CALIB) begin
         zero_offset_uv = uv_wide[UV_W-1:0];
         zero_loaded    = 1'b1;
         ma             = 0;
      end else begin
         zero = zero_loaded ? 32'(zero_offset_uv) : 32'(cfg_zero_default);
         ma   = ((longint'(uv_wide) - longint'(zero)) * longint'(MA_FACTOR)) / longint'(sens);
         if (ma > MA_HI) ma = MA_HI;
         if (ma < MA_LO) ma = MA_LO;
      end

      rd.current_ma      = ma[MA_W-1:0];
      rd.average_code    = avg[AVG_W-1:0];
      rd.sensor_uv       = uv_wide[UV_W-1:0];
      rd.was_calibration = op;
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      reading_t want, got, predicted;
      if (reset) begin
         cfg_zero_default = ZERO_RST;
         cfg_sens         = SENS_RST;
         cfg_scale        = SCALE_RST;
         cfg_ref          = REF_RST;
         cfg_full         = FULL_RST;
         cfg_avg_count    = AVGC_RST;
         cfg_calib_count  = CALC_RST;
         run_sum          = '0;
         run_tally        = '0;
         run_op           = OP_MEASURE;
         zero_offset_uv   = ZERO_RST;
         zero_loaded      = 1'b0;
         expected_readings.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_ZERO_DEFAULT: cfg_zero_default = csr_wdata[ZERO_W-1:0];
               REG_SENS:         cfg_sens         = csr_wdata[SENS_W-1:0];
               REG_SCALE:        cfg_scale        = csr_wdata[SCALE_W-1:0];
               REG_REF:          cfg_ref          = csr_wdata[REF_W-1:0];
               REG_FULL:         cfg_full         = csr_wdata[FULL_W-1:0];
               REG_AVG_COUNT:    cfg_avg_count    = csr_wdata[AVGC_W-1:0];
               REG_CALIB_COUNT:  cfg_calib_count  = csr_wdata[CALC_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.current_ma      = rsp_tdata[MA_W-1:0];
            got.average_code    = rsp_tdata[MA_W +: AVG_W];
            got.sensor_uv       = rsp_tdata[MA_W+AVG_W +: UV_W];
            got.adc_ok          = rsp_tdata[MA_W+AVG_W+UV_W];
            got.was_calibration = rsp_tuser;
            if (expected_readings.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("%0t: unexpected reading ma=%0d avg=%0d uv=%0d ok=%0b cal=%0b",
                           $time, $signed(got.current_ma), got.average_code, got.sensor_uv,
                           got.adc_ok, got.was_calibration);
               mismatch_count++;
            end else begin
               want = expected_readings.pop_front();
               if (got !== want) begin
                  if (mismatch_count < REPORT_MAX)
                     $display({"%0t: reading mismatch, exp ma=%0d avg=%0d uv=%0d ok=%0b ",
                               "cal=%0b, got ma=%0d avg=%0d uv=%0d ok=%0b cal=%0b"},
                              $time, $signed(want.current_ma), want.average_code,
                              want.sensor_uv, want.adc_ok, want.was_calibration,
                              $signed(got.current_ma), got.average_code, got.sensor_uv,
                              got.adc_ok, got.was_calibration);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (accumulate_sample(req_tuser, req_tdata, predicted))
               expected_readings.push_back(predicted);
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

>>> sim/current_sense_averager_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// current_sense_averager_tb
// Drives ADC sample beats and register writes into the current sense
// averager: a directed pass over rail codes, clamping, calibration, zero settings,
// saturation and change of operation, then randomised phases of runs with
// fresh settings each phase, random gaps on both channels and one long rsp
// hold-off. A separate checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module current_sense_averager_tb;
   import csa_pkg::*;

   localparam int SETTLE_CYCLES   = 250;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int RSP_HOLD_CYCLES = 600;
   localparam int PHASE_COUNT     = 10;
   localparam int PHASE_ITEMS     = 55;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_wr_en;
   logic [CFG_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;

   int unsigned mismatch_count;
   int unsigned readings_pending;
   int unsigned idle_cycles;

   bit no_idle      = 1'b0;
   bit hold_pending = 1'b0;

   logic [FULL_W-1:0] cur_full  = FULL_RST;
   logic [AVGC_W-1:0] cur_avg   = AVGC_RST;
   logic [CALC_W-1:0] cur_calib = CALC_RST;

   current_sense_averager u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   current_sense_averager_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .mismatch_count   (mismatch_count),
      .readings_pending (readings_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // called at a falling edge, returns at the falling edge after the beat
   task automatic send_sample(input logic op, input logic [SAMPLE_W-1:0] smp);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_FULL:        cur_full  = val[FULL_W-1:0];
         REG_AVG_COUNT:   cur_avg   = val[AVGC_W-1:0];
         REG_CALIB_COUNT: cur_calib = val[CALC_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // waits until every reading has arrived and the arithmetic has gone quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (readings_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CFG_W-1:0] draw_setting(input int width, input int unsigned hi);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CFG_W'((1 << width) - 1);
         default: return CFG_W'($urandom_range(1, hi));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      int unsigned full, near;
      full = (cur_full == 0) ? FULL_ZERO_SUB : cur_full;
      near = $urandom_range(0, 3);
      case ($urandom_range(0, 3))
         0:       return SAMPLE_W'($urandom);
         1:       return $urandom_range(0, 1) ? SAMPLE_W'(near)
                                              : SAMPLE_W'(full > near ? full - near : 0);
         default: return SAMPLE_W'($urandom_range(0, full));
      endcase
   endfunction

   // rsp side: random stalls per beat, one long hold-off on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
         end
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [SAMPLE_W-1:0] rail_codes [9];
      int   phase, sent, len, meas_len, cal_len;
      logic op;
      rail_codes = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd2047, 16'd4092, 16'd4093, 16'd4095,
                     16'hFFFF};
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_MEASURE;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // rail codes and clamping against reset settings, one sample a reading
      write_reg(REG_AVG_COUNT, 1);
      foreach (rail_codes[i]) send_sample(OP_MEASURE, rail_codes[i]);
      settle();
      write_reg(REG_ZERO_DEFAULT, {ZERO_W{1'b1}});
      send_sample(OP_MEASURE, 16'd3000);
      settle();
      write_reg(REG_ZERO_DEFAULT, 0);
      send_sample(OP_MEASURE, 16'd3000);
      settle();

      // calibration loads the zero
      write_reg(REG_CALIB_COUNT, 1);
      send_sample(OP_CALIB, 16'd2048);
      send_sample(OP_MEASURE, 16'd2048);
      send_sample(OP_CALIB, 16'hFFFF);
      settle();

      // change of operation drops the partial run
      write_reg(REG_AVG_COUNT, 4);
      send_sample(OP_MEASURE, 16'd100);
      send_sample(OP_MEASURE, 16'd200);
      send_sample(OP_CALIB, 16'd300);
      send_sample(OP_MEASURE, 16'd1000);
      send_sample(OP_MEASURE, 16'd1001);
      send_sample(OP_MEASURE, 16'd1002);
      send_sample(OP_MEASURE, 16'd1003);
      settle();

      // zero full code, zero scale and zero slope
      write_reg(REG_AVG_COUNT, 1);
      write_reg(REG_FULL, 0);
      write_reg(REG_SCALE, 0);
      write_reg(REG_SENS, 0);
      send_sample(OP_MEASURE, 16'd4095);
      send_sample(OP_MEASURE, 16'd0);
      settle();

      // voltage and current saturation both ways
      write_reg(REG_SENS, 1);
      write_reg(REG_SCALE, 1);
      write_reg(REG_REF, {REF_W{1'b1}});
      write_reg(REG_FULL, {FULL_W{1'b1}});
      send_sample(OP_MEASURE, 16'hFFFF);
      send_sample(OP_CALIB, 16'hFFFF);
      send_sample(OP_MEASURE, 16'd0);
      send_sample(OP_MEASURE, 16'hFFFF);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         no_idle = (phase == 0) || (phase % 4 == 3);
         write_reg(REG_ZERO_DEFAULT, draw_setting(ZERO_W, 10000000));
         write_reg(REG_SENS, draw_setting(SENS_W, 1000000));
         write_reg(REG_SCALE, draw_setting(SCALE_W, 65535));
         write_reg(REG_REF, draw_setting(REF_W, 5000));
         write_reg(REG_FULL, draw_setting(FULL_W, 65535));
         if (phase == 0) begin
            write_reg(REG_AVG_COUNT, 1);
         end else begin
            case ($urandom_range(0, 9))
               0:       write_reg(REG_AVG_COUNT, {AVGC_W{1'b1}});
               1:       write_reg(REG_AVG_COUNT, $urandom_range(0, 255));
               default: write_reg(REG_AVG_COUNT, $urandom_range(0, 6));
            endcase
         end
         case ($urandom_range(0, 7))
            0:       write_reg(REG_CALIB_COUNT, 0);
            1:       write_reg(REG_CALIB_COUNT, {CALC_W{1'b1}});
            default: write_reg(REG_CALIB_COUNT, $urandom_range(1, 6));
         endcase
         meas_len = (cur_avg == 0) ? 1 : cur_avg;
         cal_len  = (cur_calib == 0) ? CALC_ZERO_SUB : cur_calib;
         if (cal_len > CALIB_LIMIT) cal_len = CALIB_LIMIT;
         // readings pile up behind a stalled rsp until req is held off
         if (phase == 0) hold_pending = 1'b1;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            op  = ($urandom_range(0, 3) == 0) ? OP_CALIB : OP_MEASURE;
            len = (op == OP_CALIB) ? cal_len : meas_len;
            if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
            repeat (len) send_sample(op, draw_sample());
            sent += len;
         end
      end

      settle();
      if (mismatch_count == 0 && readings_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
